### src/imu_tilt_pkg.sv
// Shared constants, types and tables of the tilt fusion block.
`default_nettype none
package imu_tilt_pkg;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 12;
  localparam int TBL_LEN             = 24;
  localparam int ANG_W               = 24;
  localparam int CFG_W               = 16;
  localparam int CFG_IDX_W           = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_FS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd2;

  localparam logic [1:0]  FS_RESET     = 2'd1;
  localparam logic [15:0] PERIOD_RESET = 16'd6554;
  localparam logic [15:0] WEIGHT_RESET = 16'd62259;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] roll_angle;
    logic signed [23:0] pitch_angle;
    logic signed [23:0] yaw_angle;
  } angles_t;

  function automatic logic signed [27:0] atan_q20(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q20 = 28'sd47185920;
      5'd1:  atan_q20 = 28'sd27855475;
      5'd2:  atan_q20 = 28'sd14718068;
      5'd3:  atan_q20 = 28'sd7471121;
      5'd4:  atan_q20 = 28'sd3750058;
      5'd5:  atan_q20 = 28'sd1876857;
      5'd6:  atan_q20 = 28'sd938658;
      5'd7:  atan_q20 = 28'sd469357;
      5'd8:  atan_q20 = 28'sd234682;
      5'd9:  atan_q20 = 28'sd117342;
      5'd10: atan_q20 = 28'sd58671;
      5'd11: atan_q20 = 28'sd29335;
      5'd12: atan_q20 = 28'sd14668;
      5'd13: atan_q20 = 28'sd7334;
      5'd14: atan_q20 = 28'sd3667;
      5'd15: atan_q20 = 28'sd1833;
      5'd16: atan_q20 = 28'sd917;
      5'd17: atan_q20 = 28'sd458;
      5'd18: atan_q20 = 28'sd229;
      5'd19: atan_q20 = 28'sd115;
      5'd20: atan_q20 = 28'sd57;
      5'd21: atan_q20 = 28'sd29;
      5'd22: atan_q20 = 28'sd14;
      5'd23: atan_q20 = 28'sd7;
      default: atan_q20 = 28'sd0;
    endcase
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [47:0] v);
    if (v > 48'sd8388607) sat_angle = 24'sh7FFFFF;
    else if (v < -48'sd8388608) sat_angle = 24'sh800000;
    else sat_angle = v[ANG_W-1:0];
  endfunction
endpackage
`default_nettype wire

### src/imu_tilt_if.sv
// Valid/ready channel interfaces for samples and angles.
`default_nettype none
interface imu_tilt_sample_if;
  logic                      valid;
  logic                      ready;
  imu_tilt_pkg::sample_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imu_tilt_angles_if;
  logic                      valid;
  logic                      ready;
  imu_tilt_pkg::angles_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/imu_tilt_complementary_fusion.sv
// Top level of the complementary-filter tilt estimator.
`default_nettype none
// One sample is taken at a time. It passes through the gyro increments on
// the shared multiplier, a bit-pair square root, two CORDIC passes of one
// set-up step and one shared CORDIC stage, the blend of roll and pitch and
// the store. The result sits in an output register. In the cycle after it
// is handed on, the block is ready again, so no new sample is taken before
// the result is handed on.
module imu_tilt_complementary_fusion #(
  parameter int CORDIC_STEPS    = imu_tilt_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = imu_tilt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [imu_tilt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [imu_tilt_pkg::CFG_W-1:0]         cfg_data,
  imu_tilt_sample_if.sink                             sample,
  imu_tilt_angles_if.source                           angles
);
  localparam int GSH = 31 - ANGLE_FRAC_BITS;
  localparam int CSH = 20 - ANGLE_FRAC_BITS;
  localparam int NSTEP = (CORDIC_STEPS < imu_tilt_pkg::TBL_LEN) ?
                         CORDIC_STEPS : imu_tilt_pkg::TBL_LEN;
  localparam logic signed [47:0] HALF = 48'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic signed [47:0] FULL = 48'sd360 <<< ANGLE_FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_GYRO  = 8'b0000_0010,
    S_SQRT  = 8'b0000_0100,
    S_CPRE  = 8'b0000_1000,
    S_CORD  = 8'b0001_0000,
    S_BLEND = 8'b0010_0000,
    S_STORE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  logic [1:0]  gyro_fs;
  logic [15:0] period;
  logic [15:0] weight;
  logic signed [23:0] roll_store, pitch_store, yaw_store;
  imu_tilt_pkg::sample_t smp;
  logic [1:0] step;
  logic [5:0] cnt;
  logic pass;
  logic signed [47:0] g_roll, g_pitch, g_yaw;
  logic signed [47:0] a_roll, a_pitch;
  logic [33:0] root;
  logic [63:0] rad;
  logic [35:0] rem_acc;
  logic signed [40:0] cx, cy;
  logic signed [29:0] cz;
  imu_tilt_pkg::angles_t out_data;
  logic out_valid;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_fs <= imu_tilt_pkg::FS_RESET;
      period  <= imu_tilt_pkg::PERIOD_RESET;
      weight  <= imu_tilt_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imu_tilt_pkg::REG_GYRO_FS: gyro_fs <= cfg_data[1:0];
        imu_tilt_pkg::REG_PERIOD:  period  <= cfg_data;
        imu_tilt_pkg::REG_WEIGHT:  weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared gyro multiplier: raw * (fs*period)
  logic signed [15:0] g_raw;
  logic signed [23:0] store_sel;
  logic [27:0] fsp;
  logic signed [45:0] gprod;
  logic signed [47:0] gdelta;
  always_comb begin
    unique case (step)
      2'd0: begin g_raw = smp.gyro_x; store_sel = roll_store; end
      2'd1: begin g_raw = smp.gyro_y; store_sel = pitch_store; end
      default: begin g_raw = smp.gyro_z; store_sel = yaw_store; end
    endcase
    fsp    = ({10'd0, period, 2'd0} * 28'd250) >> 2 << gyro_fs;
    gprod  = g_raw * $signed({1'b0, fsp});
    gdelta = (48'(gprod) + (48'sd1 <<< (GSH - 1))) >>> GSH;
  end

  // square root step, two bits per cycle
  logic [63:0] rem_sh;
  logic [35:0] rem_hi;
  logic [35:0] try_v;
  always_comb begin
    try_v = {root, 2'b01};
    rem_hi = {rem_acc[33:0], rad[63:62]};
    rem_sh = {rad[61:0], 2'b00};
  end

  // CORDIC stage
  logic [4:0] ci;
  logic signed [40:0] xs, ys;
  logic signed [29:0] at;
  always_comb begin
    ci = cnt[4:0];
    xs = cx >>> ci;
    ys = cy >>> ci;
    at = 30'(imu_tilt_pkg::atan_q20(ci));
  end
  logic signed [47:0] cres;
  always_comb
    cres = (48'(cz) + ((CSH > 0) ? (48'sd1 <<< (CSH - 1)) : 48'sd0)) >>> CSH;

  // blend multiplier
  logic signed [47:0] bg, ba;
  logic signed [66:0] bsum;
  logic signed [47:0] bres;
  always_comb begin
    bg   = step[0] ? g_pitch : g_roll;
    ba   = step[0] ? a_pitch : a_roll;
    bsum = 67'(bg) * $signed({1'b0, weight}) +
           67'(ba) * $signed(18'(32'd65536 - {16'd0, weight}));
    bres = 48'((bsum + 67'sd32768) >>> 16);
  end
  logic signed [47:0] yw;
  always_comb begin
    if (g_yaw > HALF) yw = g_yaw - FULL;
    else if (g_yaw < -HALF) yw = g_yaw + FULL;
    else yw = g_yaw;
  end

  logic signed [16:0] nax;
  always_comb nax = -17'(smp.accel_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      roll_store <= '0; pitch_store <= '0; yaw_store <= '0;
      step <= '0; cnt <= '0; pass <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (sample.valid) begin
          smp <= sample.data;
          step <= '0;
          state <= S_GYRO;
        end
        S_GYRO: begin
          unique case (step)
            2'd0: g_roll  <= 48'(store_sel) + gdelta;
            2'd1: g_pitch <= 48'(store_sel) + gdelta;
            default: g_yaw <= 48'(store_sel) + gdelta;
          endcase
          if (step == 2'd2) begin
            step <= '0;
            cnt <= '0;
            rad <= {32'(34'(32'(smp.accel_x) * 32'(smp.accel_x)) +
                        34'(32'(smp.accel_z) * 32'(smp.accel_z))), 32'd0};
            rem_acc <= '0;
            root <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_SQRT: begin
          // work all 32 bit pairs of the radicand
          rad <= rem_sh;
          if (rem_hi >= try_v) begin
            rem_acc <= rem_hi - try_v;
            root <= {root[32:0], 1'b1};
          end else begin
            rem_acc <= rem_hi;
            root <= {root[32:0], 1'b0};
          end
          if (cnt == 6'd31) begin
            pass <= 1'b0;
            state <= S_CPRE;
          end
          cnt <= cnt + 6'd1;
        end
        S_CPRE: begin
          logic signed [40:0] xv, yv;
          xv = pass ? $signed({7'd0, root}) : (41'(smp.accel_z) <<< 16);
          yv = pass ? (41'(smp.accel_y) <<< 16) : (41'(nax) <<< 16);
          cnt <= '0;
          if (xv == 0 && yv == 0) begin
            cx <= '0; cy <= '0; cz <= '0;
          end else if (xv < 0 && yv >= 0) begin
            cx <= yv; cy <= -xv; cz <= 30'sd94371840;
          end else if (xv < 0) begin
            cx <= -yv; cy <= xv; cz <= -30'sd94371840;
          end else begin
            cx <= xv; cy <= yv; cz <= '0;
          end
          state <= S_CORD;
        end
        S_CORD: begin
          if (cy > 0) begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
          end else if (cx != 0 || cy != 0) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
          end
          if (cnt == 6'(NSTEP)) begin
            if (pass) begin
              a_pitch <= cres;
              step <= '0;
              state <= S_BLEND;
            end else begin
              a_roll <= cres;
              pass <= 1'b1;
              state <= S_CPRE;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_BLEND: begin
          if (step[0]) begin
            pitch_store <= imu_tilt_pkg::sat_angle(bres);
            state <= S_STORE;
          end else begin
            roll_store <= imu_tilt_pkg::sat_angle(bres);
          end
          step <= step + 2'd1;
        end
        S_STORE: begin
          yaw_store <= imu_tilt_pkg::sat_angle(yw);
          out_data.roll_angle  <= roll_store;
          out_data.pitch_angle <= pitch_store;
          out_data.yaw_angle   <= imu_tilt_pkg::sat_angle(yw);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (angles.ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign angles.valid = out_valid;
  assign angles.data  = out_data;
endmodule
`default_nettype wire

### src/imu_tilt_checker.sv
// Port-level checks of the tilt fusion block, bound to the top level.
`default_nettype none
module imu_tilt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("sample taken while result pending");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after take");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_no_out_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
endmodule

bind imu_tilt_complementary_fusion imu_tilt_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(sample.valid), .in_ready(sample.ready),
  .out_valid(angles.valid), .out_ready(angles.ready)
);
`default_nettype wire
